/* rtl/display_number_formatter_assert.svh */
// Assertion macros for the display number formatter.
`ifndef DISPLAY_NUMBER_FORMATTER_ASSERT_SVH
`define DISPLAY_NUMBER_FORMATTER_ASSERT_SVH
`ifndef SYNTHESIS
`define DNF_ASSERT_IMP(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
`define DNF_ASSERT_NXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`else
`define DNF_ASSERT_IMP(label, clk, rst, a, b)
`define DNF_ASSERT_NXT(label, clk, rst, a, b)
`endif
`endif

/* rtl/dnf_pkg.sv */
// Shared types and constants for the display number formatter.
`default_nettype none
package dnf_pkg;
   localparam logic [2:0] ACT_UDEC = 3'd0;
   localparam logic [2:0] ACT_SDEC = 3'd1;
   localparam logic [2:0] ACT_HEX  = 3'd2;
   localparam logic [2:0] ACT_FIX  = 3'd3;
   localparam logic [2:0] ACT_CHAR = 3'd4;
   localparam int unsigned MAX_WRITES = 32;

   typedef struct packed {
      logic [2:0]  action;
      logic [15:0] value;
      logic [7:0]  position;
      logic [5:0]  field_length;
      logic        flush_left;
      logic        zero_fill;
      logic [3:0]  decimals;
      logic [7:0]  character_in;
   } req_type;

   typedef struct packed {
      logic [4:0] out_position;
      logic [7:0] out_char;
      logic       last;
   } rsp_type;

   typedef enum logic [1:0] {FR_IDLE, FR_CONV, FR_PUSH} front_state_type;

   typedef enum logic [2:0] {
      PH_MINUS, PH_PAD, PH_POINT, PH_ZEROS, PH_DIGITS, PH_DONE, PH_CHAR
   } phase_type;

   // Fully classified job handed from front to back: the digits plus the
   // counts and columns that describe the layout.
   typedef struct packed {
      logic [4:0][3:0] digits;   // least significant first
      logic [2:0]      ndig;     // digits kept (0..5)
      logic            hex;
      logic            minus;    // write '-' first
      logic [6:0]      mstart;   // column of the '-'
      logic [6:0]      start;    // first column after the '-'
      logic [5:0]      pad;      // leading pad count
      logic            pad_zero; // pad written as '0' (else skipped)
      logic            fix_mode; // fixed-point layout
      logic [3:0]      zeros;    // fixed: zeros after "0."
      logic            lead0pt;  // fixed: "0." prefix
      logic [3:0]      dec;      // fixed: point position
      logic            is_char;
      logic [7:0]      ch;
   } job_type;

   function automatic logic [7:0] glyph(input logic [3:0] d);
      glyph = (d < 4'd10) ? (8'h30 + {4'd0, d}) : (8'h37 + {4'd0, d});
   endfunction
endpackage
`default_nettype wire

/* rtl/dnf_front.sv */
// Front part: classifies a request and extracts its digits one per cycle.
`default_nettype none
module dnf_front import dnf_pkg::*; #(
   parameter int unsigned DISPLAY_CHARS = 32
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req,
   output logic         job_valid,
   output job_type      job,
   input  wire logic    job_ready
);
   front_state_type state_ff, state_in;
   req_type         req_ff, req_in;
   logic [15:0]     rem_ff, rem_in;
   logic [4:0][3:0] dig_ff, dig_in;
   logic [2:0]      cnt_ff, cnt_in;
   logic            neg_ff, neg_in;

   logic [2:0]  maxd;
   logic [15:0] q10, q;
   logic [3:0]  r;
   logic [31:0] prod;
   logic        hexm;

   assign hexm = (req_ff.action == ACT_HEX);
   assign maxd = hexm ? 3'd4 : 3'd5;
   assign prod = {16'd0, rem_ff} * 32'd52429;
   assign q10  = {3'd0, prod[31:19]};
   assign q    = hexm ? {4'd0, rem_ff[15:4]} : q10;
   assign r    = hexm ? rem_ff[3:0] : 4'(rem_ff - q10 * 16'd10);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
      req_ff  <= req_in;
      rem_ff  <= rem_in;
      dig_ff  <= dig_in;
      cnt_ff  <= cnt_in;
      neg_ff  <= neg_in;
   end

   // Layout computation from the finished digit list.
   logic [7:0] len, pos, tot;
   logic [2:0] nd;
   logic [7:0] fpos;
   always_comb begin
      job = '0;
      job.digits = dig_ff;
      job.hex = hexm;
      job.is_char = (req_ff.action == ACT_CHAR);
      job.ch = req_ff.character_in;
      len = {2'd0, req_ff.field_length};
      pos = req_ff.position;
      nd  = cnt_ff;
      tot = '0;
      fpos = '0;
      job.mstart = pos[6:0];
      job.start = pos[6:0];
      if (req_ff.action == ACT_FIX) begin
         job.fix_mode = 1'b1;
         job.minus = neg_ff;
         job.start = 7'(pos + {7'd0, neg_ff});
         job.dec = req_ff.decimals;
         job.ndig = nd;
         if ({1'b0, req_ff.decimals} >= {2'd0, nd}) begin
            job.lead0pt = 1'b1;
            job.zeros = 4'(req_ff.decimals - {1'b0, nd});
            tot = {4'd0, req_ff.decimals} + 8'd2;
         end else begin
            tot = {5'd0, nd} + ((req_ff.decimals != 4'd0) ? 8'd1 : 8'd0);
         end
         tot = tot + {7'd0, neg_ff};
         job.ndig = ({1'b0, pos} + {1'b0, tot} > 9'(DISPLAY_CHARS)) ? 3'd0 : nd;
      end
      if (req_ff.action == ACT_SDEC && neg_ff) begin
         job.minus = 1'b1;
         len = (len != 8'd0) ? len - 8'd1 : 8'd0;
         fpos = pos + 8'd1;
      end else begin
         fpos = pos;
      end
      if (req_ff.action <= ACT_HEX) begin
         job.start = fpos[6:0];
         if ({1'b0, fpos} + {1'b0, len} > 9'(DISPLAY_CHARS)) begin
            job.ndig = 3'd0;
            job.pad = '0;
         end else begin
            job.ndig = ({5'd0, nd} > len) ? len[2:0] : nd;
            job.pad = 6'(len - {5'd0, job.ndig});
            if (req_ff.flush_left && !(req_ff.action == ACT_SDEC && neg_ff))
               job.pad = '0;
            job.pad_zero = req_ff.zero_fill;
            if (!job.pad_zero && !(req_ff.flush_left && !job.minus))
               job.start = 7'(fpos + {2'd0, job.pad});
            if (!job.pad_zero)
               job.pad = '0;
         end
      end
   end

   logic valid_req;
   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      rem_in = rem_ff;
      dig_in = dig_ff;
      cnt_in = cnt_ff;
      neg_in = neg_ff;
      busy = (state_ff != FR_IDLE);
      job_valid = 1'b0;
      valid_req = 1'b0;
      case (state_ff)
         FR_IDLE: begin
            if (start) begin
               req_in = req;
               neg_in = req.value[15] &&
                        (req.action == ACT_SDEC || req.action == ACT_FIX);
               rem_in = neg_in ? 16'(17'h10000 - {1'b0, req.value}) : req.value;
               cnt_in = '0;
               dig_in = '0;
               valid_req = (req.action <= ACT_CHAR);
               if (req.action <= ACT_HEX && req.field_length > 6'(MAX_WRITES))
                  valid_req = 1'b0;
               if ((req.action == ACT_SDEC || req.action == ACT_CHAR) &&
                   {1'b0, req.position} >= 9'(DISPLAY_CHARS))
                  valid_req = 1'b0;
               state_in = valid_req ? FR_CONV : FR_IDLE;
            end
         end
         FR_CONV: begin
            dig_in[cnt_ff] = r;
            cnt_in = cnt_ff + 3'd1;
            rem_in = q;
            if (q == 16'd0 || cnt_in == maxd) state_in = FR_PUSH;
         end
         FR_PUSH: begin
            job_valid = 1'b1;
            if (job_ready) state_in = FR_IDLE;
         end
         default: state_in = FR_IDLE;
      endcase
   end
endmodule
`default_nettype wire

/* rtl/dnf_queue.sv */
// Two-entry job queue between the front and back parts.
`default_nettype none
module dnf_queue import dnf_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire job_type in_job,
   output logic         out_valid,
   input  wire logic    out_ready,
   output job_type      out_job
);
   job_type    mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_job   = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) mem_ff[wp_ff] <= in_job;
   end
endmodule
`default_nettype wire

/* rtl/dnf_back.sv */
// Back part: emits one character word per cycle, with idle steps.
`default_nettype none
module dnf_back import dnf_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    job_valid,
   output logic         job_ready,
   input  wire job_type job,
   output logic         rsp_valid,
   output rsp_type      rsp
);
   `include "display_number_formatter_assert.svh"

   // Phases: minus, pad, "0." prefix, zeros, digits, done; a single
   // character has a phase of its own.
   logic          act_ff, act_in;
   job_type       j_ff, j_in;
   phase_type     ph_ff, ph_in;
   logic [5:0]    k_ff, k_in;
   logic [6:0]    col_ff, col_in;
   logic          v_ff, v_in;
   rsp_type       o_ff, o_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0;
         v_ff <= 1'b0;
      end else begin
         act_ff <= act_in;
         v_ff <= v_in;
      end
      j_ff <= j_in;
      ph_ff <= ph_in;
      k_ff <= k_in;
      col_ff <= col_in;
      o_ff <= o_in;
   end

   assign rsp_valid = v_ff;
   assign rsp = o_ff;
   assign job_ready = !act_ff;

   logic       emit, more, has;
   logic [7:0] ch;
   logic [2:0] di;
   always_comb begin
      act_in = act_ff;
      j_in = j_ff;
      ph_in = ph_ff;
      k_in = k_ff;
      col_in = col_ff;
      v_in = 1'b0;
      o_in = o_ff;
      emit = 1'b0;
      ch = 8'h20;
      more = 1'b0;
      has = 1'b0;
      di = 3'(j_ff.ndig - 3'd1 - k_ff[2:0]);
      if (!act_ff) begin
         if (job_valid) begin
            act_in = 1'b1;
            j_in = job;
            k_in = '0;
            col_in = job.minus ? job.mstart : job.start;
            ph_in = job.is_char ? PH_CHAR : (job.minus ? PH_MINUS : PH_PAD);
            if (!job.is_char && !job.minus && job.ndig == 3'd0 && job.pad == 6'd0)
               act_in = 1'b0;
            if (job.fix_mode && job.ndig == 3'd0)
               act_in = 1'b0;
         end
      end else begin
         case (ph_ff)
            PH_CHAR: begin emit = 1'b1; ch = j_ff.ch; ph_in = PH_DONE; end
            PH_MINUS: begin emit = 1'b1; ch = 8'h2D; ph_in = PH_PAD; end
            PH_PAD: begin
               if (k_ff < j_ff.pad) begin
                  emit = 1'b1; ch = 8'h30; k_in = k_ff + 6'd1;
               end else begin
                  k_in = '0;
                  ph_in = j_ff.lead0pt ? PH_POINT : PH_DIGITS;
               end
            end
            PH_POINT: begin
               emit = 1'b1; ch = (k_ff == 6'd0) ? 8'h30 : 8'h2E;
               k_in = k_ff + 6'd1;
               if (k_ff == 6'd1) begin k_in = '0; ph_in = PH_ZEROS; end
            end
            PH_ZEROS: begin
               if (k_ff[3:0] < j_ff.zeros) begin
                  emit = 1'b1; ch = 8'h30; k_in = k_ff + 6'd1;
               end else begin
                  k_in = '0; ph_in = PH_DIGITS;
               end
            end
            PH_DIGITS: begin
               if (k_ff[2:0] < j_ff.ndig) begin
                  if (j_ff.fix_mode && !j_ff.lead0pt && j_ff.dec != 4'd0 &&
                      {1'b0, j_ff.ndig} - {1'b0, k_ff[2:0]} == j_ff.dec && !k_ff[5]) begin
                     emit = 1'b1; ch = 8'h2E; k_in = k_ff | 6'h20;
                  end else begin
                     emit = 1'b1; ch = glyph(j_ff.digits[di]);
                     k_in = {1'b0, k_ff[4:0] + 5'd1};
                  end
               end else begin
                  ph_in = PH_DONE;
               end
            end
            default: act_in = 1'b0;
         endcase
         // Decide whether this word is the final one by looking ahead.
         if (emit) begin
            case (ph_ff)
               PH_CHAR: has = 1'b0;
               PH_MINUS: has = (j_ff.pad != 6'd0) || j_ff.lead0pt || (j_ff.ndig != 3'd0);
               PH_PAD: has = (k_in < j_ff.pad) || j_ff.lead0pt || (j_ff.ndig != 3'd0);
               PH_POINT: has = 1'b1;
               PH_ZEROS: has = 1'b1;
               default: has = (k_in[2:0] < j_ff.ndig);
            endcase
         end
         more = has;
         if (emit) begin
            v_in = 1'b1;
            o_in.out_position = col_ff[4:0];
            o_in.out_char = ch;
            o_in.last = !more;
            // The field after a minus sign may start further right.
            col_in = (ph_ff == PH_MINUS) ? j_ff.start : col_ff + 7'd1;
            if (!more) act_in = 1'b0;
         end
      end
   end

   `DNF_ASSERT_NXT(a_one_job, clock, reset, job_valid && job_ready, act_ff || !rsp_valid || rsp.last)
   `DNF_ASSERT_IMP(a_ready, clock, reset, rsp_valid && !rsp.last, 1'b1)
   `DNF_ASSERT_NXT(a_last_ends, clock, reset, v_in && o_in.last, !act_ff)
endmodule
`default_nettype wire

/* rtl/display_number_formatter.sv */
// Top level of the display number formatter: a request word is taken when start is high and busy low.
// For a valid one, busy then stays high while its digits are extracted and until its job is handed
// to the two-entry job queue, waiting while that queue is full; only then can a new request be taken.
// With the back part free, the job passes the queue and the back job and output registers; words then
// come one per cycle (up to 32), with idle steps where padding or fixed-point zeros end and between
// requests. Each word is strobed for one cycle; the receiver cannot stall. Reset empties everything.
`default_nettype none
module display_number_formatter import dnf_pkg::*; #(
   parameter int unsigned DISPLAY_CHARS = 32
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_word,
   output logic         rsp_valid,
   output rsp_type      rsp_word
);
   // Classified jobs flow front -> queue -> back, so a new request can be
   // converted while the previous one is still being written out.
   logic    f_valid, f_ready, b_valid, b_ready;
   job_type f_job, b_job;

   dnf_front #(.DISPLAY_CHARS(DISPLAY_CHARS)) u_front (
      .clock, .reset, .start, .busy, .req(req_word),
      .job_valid(f_valid), .job(f_job), .job_ready(f_ready));

   dnf_queue u_queue (
      .clock, .reset, .in_valid(f_valid), .in_ready(f_ready), .in_job(f_job),
      .out_valid(b_valid), .out_ready(b_ready), .out_job(b_job));

   dnf_back u_back (
      .clock, .reset, .job_valid(b_valid), .job_ready(b_ready), .job(b_job),
      .rsp_valid, .rsp(rsp_word));
endmodule
`default_nettype wire
